// ----- hw/rtl/ccx_pkg.sv -----
// package for the chacha20-style keystream xor block, non-standard sigma
// types and constants for all modules, round functions for the datapath
package ccx_pkg;

    localparam int DoubleRoundsDefault = 10;
    localparam int BlockBytes = 64;
    localparam int AddrWidth = 6;

    localparam logic [31:0] Sigma0 = 32'h73696874;
    localparam logic [31:0] Sigma1 = 32'h20736920;
    localparam logic [31:0] Sigma2 = 32'h20746f6e;
    localparam logic [31:0] Sigma3 = 32'h6967616d;

    localparam logic [2:0] RegKey01   = 3'd0;
    localparam logic [2:0] RegKey23   = 3'd1;
    localparam logic [2:0] RegKey45   = 3'd2;
    localparam logic [2:0] RegKey67   = 3'd3;
    localparam logic [2:0] RegNonce01 = 3'd4;
    localparam logic [2:0] RegNonce2  = 3'd5;
    localparam logic [2:0] RegInitCtr = 3'd6;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] block_t;

    typedef struct packed {
        logic load;      // load working words from input words
        logic round;     // one column or diagonal round
        logic diag;      // diagonal round when high
        logic finish;    // add input words back, advance counter
        logic restart;   // reload counter and nonce word
        logic consume;   // output the next byte, advance position
    } ccx_cmd_t;

    typedef struct packed {
        logic need_block;
    } ccx_status_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter(input word_t a, input word_t b,
                                             input word_t c, input word_t d);
        word_t a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        quarter = {a1, b1, c1, d1};
    endfunction

endpackage

// ----- hw/rtl/ccx_datapath.sv -----
// datapath: working words, input words, keystream block, counter and byte position
// depends on ccx_pkg
module ccx_datapath
    import ccx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ccx_cmd_t    cmd,
    output ccx_status_t status,
    input  logic [63:0] key01,
    input  logic [63:0] key23,
    input  logic [63:0] key45,
    input  logic [63:0] key67,
    input  logic [63:0] nonce01,
    input  logic [31:0] nonce2,
    input  logic [31:0] init_ctr,
    input  logic [7:0]  data_byte,
    output logic [7:0]  ks_xor
);

    block_t work_reg;
    block_t init_reg;
    block_t ks_reg;
    block_t init_words;
    block_t round_out;
    logic [31:0] ctr_reg, ctr_next;
    logic [31:0] nonce_reg, nonce_next;
    logic [6:0]  pos_reg;
    logic [31:0] ks_word;

    always_comb
    begin
        init_words[0]  = Sigma0;
        init_words[1]  = Sigma1;
        init_words[2]  = Sigma2;
        init_words[3]  = Sigma3;
        init_words[4]  = key01[31:0];
        init_words[5]  = key01[63:32];
        init_words[6]  = key23[31:0];
        init_words[7]  = key23[63:32];
        init_words[8]  = key45[31:0];
        init_words[9]  = key45[63:32];
        init_words[10] = key67[31:0];
        init_words[11] = key67[63:32];
        init_words[12] = ctr_reg;
        init_words[13] = nonce_reg;
        init_words[14] = nonce01[63:32];
        init_words[15] = nonce2;
    end

    always_comb
    begin
        round_out = work_reg;
        if (!cmd.diag)
        begin
            {round_out[0], round_out[4], round_out[8], round_out[12]} =
                quarter(work_reg[0], work_reg[4], work_reg[8], work_reg[12]);
            {round_out[1], round_out[5], round_out[9], round_out[13]} =
                quarter(work_reg[1], work_reg[5], work_reg[9], work_reg[13]);
            {round_out[2], round_out[6], round_out[10], round_out[14]} =
                quarter(work_reg[2], work_reg[6], work_reg[10], work_reg[14]);
            {round_out[3], round_out[7], round_out[11], round_out[15]} =
                quarter(work_reg[3], work_reg[7], work_reg[11], work_reg[15]);
        end
        else
        begin
            {round_out[0], round_out[5], round_out[10], round_out[15]} =
                quarter(work_reg[0], work_reg[5], work_reg[10], work_reg[15]);
            {round_out[1], round_out[6], round_out[11], round_out[12]} =
                quarter(work_reg[1], work_reg[6], work_reg[11], work_reg[12]);
            {round_out[2], round_out[7], round_out[8], round_out[13]} =
                quarter(work_reg[2], work_reg[7], work_reg[8], work_reg[13]);
            {round_out[3], round_out[4], round_out[9], round_out[14]} =
                quarter(work_reg[3], work_reg[4], work_reg[9], work_reg[14]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= init_words;
            init_reg <= init_words;
        end
        else if (cmd.round)
        begin
            work_reg <= round_out;
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= work_reg[i] + init_reg[i];
            end
        end
    end

    always_comb
    begin
        ctr_next   = ctr_reg;
        nonce_next = nonce_reg;
        if (cmd.restart)
        begin
            ctr_next   = init_ctr;
            nonce_next = nonce01[31:0];
        end
        else if (cmd.finish)
        begin
            ctr_next = ctr_reg + 32'd1;
            if (ctr_reg == 32'hffffffff)
            begin
                nonce_next = nonce_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg   <= '0;
            nonce_reg <= '0;
            pos_reg   <= 7'(BlockBytes);
        end
        else
        begin
            ctr_reg   <= ctr_next;
            nonce_reg <= nonce_next;
            if (cmd.restart)
            begin
                pos_reg <= 7'(BlockBytes);
            end
            else if (cmd.finish)
            begin
                pos_reg <= '0;
            end
            else if (cmd.consume)
            begin
                pos_reg <= pos_reg + 7'd1;
            end
        end
    end

    assign status.need_block = pos_reg[6];
    assign ks_word = ks_reg[pos_reg[5:2]];
    assign ks_xor  = data_byte ^ 8'(ks_word >> {pos_reg[1:0], 3'b000});

endmodule

// ----- hw/rtl/ccx_ctrl.sv -----
// controller: accepts bytes, sequences block generation and the output register
// depends on ccx_pkg
module ccx_ctrl
    import ccx_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DoubleRoundsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    input  logic        last_byte,
    input  logic [7:0]  ks_xor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_out,
    input  ccx_status_t status,
    output ccx_cmd_t    cmd
);

    localparam int RoundCount = 2 * DOUBLE_ROUNDS;
    localparam int RcWidth = $clog2(RoundCount + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [RcWidth-1:0] rc_reg, rc_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       valid_reg, valid_next;
    logic       take;
    logic       out_free;

    assign out_free  = !valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign take      = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rc_next    = rc_reg;
        valid_next = valid_reg && out_stall;
        cmd        = '0;
        cmd.diag   = rc_reg[0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.restart = restart;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.need_block)
                begin
                    cmd.load   = 1'b1;
                    rc_next    = '0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                if (rc_reg == RcWidth'(RoundCount))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.round = 1'b1;
                    rc_next   = rc_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.consume = 1'b1;
                    valid_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rc_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg <= last_byte;
        end
        if (cmd.consume)
        begin
            data_reg <= ks_xor;
            last_out <= last_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |=> valid_reg && $stable(data_reg))
        else $error("result changed while stalled");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RcWidth'(RoundCount))
        else $error("round count overran");
    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == ST_LOAD)
        else $error("accepted byte not processed");
    a_consume_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.consume |-> state_reg == ST_EMIT && !status.need_block)
        else $error("byte consumed without keystream");

endmodule

// ----- hw/rtl/chacha20_keystream_xor_top.sv -----
// chacha20 keystream xor block, top level with configuration registers
// depends on ccx_pkg, ccx_ctrl, ccx_datapath
//
// input channel: data_byte, restart, last_byte with in_valid / in_stall
// output channel: out_byte, last_out with out_valid / out_stall
// one result per input byte, the byte xored with the next keystream byte
// a byte inside a block passes the load and emit steps between transfer and result valid
// a byte that opens a new block also passes the round step between these, in the
// single round unit that runs one column or diagonal round per cycle
// the next transfer can be taken in the same cycle that the result becomes valid
// restart reloads the counter and nonce word 0 and forces a new block
// configuration registers at 8*i over a 64-bit apb port, write only while idle
// reset clears counter, nonce word, registers and forces a new block
// a stalled result is held; the next byte then waits in the emit step
module chacha20_keystream_xor_top
    import ccx_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DoubleRoundsDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 restart,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 last_out
);

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    logic [31:0] nonce2_reg, init_ctr_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;
    ccx_cmd_t    cmd;
    ccx_status_t status;
    logic [7:0]  ks_xor;
    logic [7:0]  data_hold_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg    <= '0;
            key23_reg    <= '0;
            key45_reg    <= '0;
            key67_reg    <= '0;
            nonce01_reg  <= '0;
            nonce2_reg   <= '0;
            init_ctr_reg <= '0;
        end
        else if (wr_en && paddr[2:0] == 3'b000)
        begin
            unique case (reg_idx)
                RegKey01:   key01_reg    <= pwdata;
                RegKey23:   key23_reg    <= pwdata;
                RegKey45:   key45_reg    <= pwdata;
                RegKey67:   key67_reg    <= pwdata;
                RegNonce01: nonce01_reg  <= pwdata;
                RegNonce2:  nonce2_reg   <= pwdata[31:0];
                RegInitCtr: init_ctr_reg <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RegKey01:   prdata = key01_reg;
            RegKey23:   prdata = key23_reg;
            RegKey45:   prdata = key45_reg;
            RegKey67:   prdata = key67_reg;
            RegNonce01: prdata = nonce01_reg;
            RegNonce2:  prdata = {32'd0, nonce2_reg};
            RegInitCtr: prdata = {32'd0, init_ctr_reg};
            default:    prdata = '0;
        endcase
    end

    ccx_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .last_byte (last_byte),
        .ks_xor    (ks_xor),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_out  (last_out),
        .status    (status),
        .cmd       (cmd)
    );

    ccx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .key01     (key01_reg),
        .key23     (key23_reg),
        .key45     (key45_reg),
        .key67     (key67_reg),
        .nonce01   (nonce01_reg),
        .nonce2    (nonce2_reg),
        .init_ctr  (init_ctr_reg),
        .data_byte (data_hold_reg),
        .ks_xor    (ks_xor)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_hold_reg <= data_byte;
        end
    end

endmodule
